// ===== sv/pci_pkg.sv =====
// Package for the step-function integrator: widths, codes, state and interface types.
`default_nettype none

package pci_pkg;

    // Table depth
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CFG_W      = 7;
    localparam int CNT_W      = ($clog2(MAX_POINTS + 1) > CFG_W) ?
                                $clog2(MAX_POINTS + 1) : CFG_W;

    // Field widths
    localparam int TIME_W = 24;
    localparam int VAL_W  = 16;
    localparam int OUT_W  = 48;

    // Datapath widths
    localparam int SPAN_W   = TIME_W + 1;
    localparam int VSQ_W    = 2 * VAL_W - 1;
    localparam int PPROD_W  = VAL_W + SPAN_W + 1;
    localparam int SPROD_W  = VSQ_W + SPAN_W;
    localparam int SQ_SHIFT = 14;

    localparam int PACC_RAW = PPROD_W + IDX_W;
    localparam int PACC_W   = (PACC_RAW > OUT_W + 1) ? PACC_RAW : OUT_W + 1;
    localparam int SACC_RAW = SPROD_W + IDX_W;
    localparam int SACC_W   = (SACC_RAW > OUT_W + SQ_SHIFT + 1) ?
                              SACC_RAW : OUT_W + SQ_SHIFT + 1;

    localparam logic [SPAN_W-1:0] TIME_LIMIT = {1'b1, {TIME_W{1'b0}}};
    localparam logic [SACC_W:0]   SQ_HALF    = (SACC_W + 1)'(1) << (SQ_SHIFT - 1);
    localparam logic [OUT_W-1:0]  OUT_MAX    = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0]  OUT_MIN    = {1'b1, {(OUT_W - 1){1'b0}}};

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    typedef struct packed {
        logic load_we;
        logic cfg_we;
        logic query_start;
        logic walk;
        logic round;
    } cmd_t;

    typedef struct packed {
        logic walk_last;
        logic pipe_empty;
    } sts_t;

endpackage

`default_nettype wire

// ===== sv/pci_ctrl.sv =====
// Controller state machine for the step-function integrator.
`default_nettype none

module pci_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          op,
    input  wire logic          cfg_valid,
    input  wire pci_pkg::sts_t sts,
    output pci_pkg::cmd_t      cmd,
    output logic               busy,
    output logic               cfg_ready,
    output logic               done
);

    pci_pkg::state_t state_reg;
    pci_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= pci_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            pci_pkg::ST_IDLE:
            begin
                cmd.cfg_we = cfg_valid;
                if (start) begin
                    if (op == pci_pkg::OP_QUERY) begin
                        cmd.query_start = 1'b1;
                        state_next      = pci_pkg::ST_WALK;
                    end else begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            pci_pkg::ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_last) begin
                    state_next = pci_pkg::ST_DRAIN;
                end
            end
            pci_pkg::ST_DRAIN:
            begin
                if (sts.pipe_empty) begin
                    state_next = pci_pkg::ST_ROUND;
                end
            end
            pci_pkg::ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = pci_pkg::ST_OUT;
            end
            pci_pkg::ST_OUT:
            begin
                state_next = pci_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pci_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != pci_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == pci_pkg::ST_IDLE);
    assign done      = (state_reg == pci_pkg::ST_OUT);

endmodule

`default_nettype wire

// ===== sv/pci_datapath.sv =====
// Datapath: breakpoint table, segment walk pipeline, accumulators and result rounding.
`default_nettype none

module pci_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pci_pkg::cmd_t                     cmd,
    output pci_pkg::sts_t                          sts,
    input  wire logic [pci_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic [5:0]                        entry_index,
    input  wire logic [pci_pkg::TIME_W-1:0]        entry_time,
    input  wire logic signed [pci_pkg::VAL_W-1:0]  entry_value,
    input  wire logic [pci_pkg::TIME_W-1:0]        start_time,
    input  wire logic [pci_pkg::TIME_W-1:0]        end_time,
    input  wire logic                              squared,
    output logic signed [pci_pkg::OUT_W-1:0]       integral,
    output logic                                   saturated
);

    // Breakpoint table
    logic [pci_pkg::TIME_W-1:0]       time_mem [pci_pkg::MAX_POINTS];
    logic signed [pci_pkg::VAL_W-1:0] val_mem  [pci_pkg::MAX_POINTS];

    logic [pci_pkg::CFG_W-1:0]  points_reg;
    logic [pci_pkg::CNT_W-1:0]  points_ext;
    logic [pci_pkg::CNT_W-1:0]  active_n;
    logic [pci_pkg::IDX_W-1:0]  n_last_reg;
    logic [pci_pkg::IDX_W-1:0]  j_reg;
    logic [pci_pkg::IDX_W-1:0]  time_addr;
    logic [pci_pkg::IDX_W-1:0]  load_addr;
    logic                       load_ok;

    logic [pci_pkg::TIME_W-1:0] s_reg;
    logic [pci_pkg::TIME_W-1:0] e_reg;
    logic                       sq_sel_reg;

    // Read stage
    logic                             s1_valid_reg;
    logic                             s1_first_reg;
    logic                             s1_last_reg;
    logic [pci_pkg::TIME_W-1:0]       rd_time_reg;
    logic signed [pci_pkg::VAL_W-1:0] rd_val_reg;
    logic [pci_pkg::TIME_W-1:0]       prev_hi_reg;

    // Span stage
    logic [pci_pkg::SPAN_W-1:0]       seg_lo;
    logic [pci_pkg::SPAN_W-1:0]       seg_hi;
    logic [pci_pkg::SPAN_W-1:0]       clip_a;
    logic [pci_pkg::SPAN_W-1:0]       clip_b;
    logic [pci_pkg::SPAN_W-1:0]       span;
    logic signed [2*pci_pkg::VAL_W-1:0] vsq_full;
    logic                             s2_valid_reg;
    logic [pci_pkg::SPAN_W-1:0]       dt_reg;
    logic signed [pci_pkg::VAL_W-1:0] val2_reg;
    logic [pci_pkg::VSQ_W-1:0]        vsq_reg;

    // Product stage
    logic                              s3_valid_reg;
    logic signed [pci_pkg::PPROD_W-1:0] pprod_reg;
    logic [pci_pkg::SPROD_W-1:0]        sprod_reg;

    // Accumulators
    logic signed [pci_pkg::PACC_W-1:0] acc_plain_reg;
    logic [pci_pkg::SACC_W-1:0]        acc_sq_reg;

    // Rounding
    logic [pci_pkg::SACC_W:0]               sq_sum;
    logic                                   sq_ovf;
    logic [pci_pkg::PACC_W-pci_pkg::OUT_W:0] plain_top;
    logic                                   plain_ovf;
    logic [pci_pkg::OUT_W-1:0]              result_next;
    logic                                   sat_next;
    logic [pci_pkg::OUT_W-1:0]              result_reg;
    logic                                   sat_reg;

    assign load_addr = pci_pkg::IDX_W'(entry_index);
    assign load_ok   = (pci_pkg::CNT_W'(entry_index) < pci_pkg::CNT_W'(pci_pkg::MAX_POINTS));

    always_ff @(posedge clk) begin
        if (cmd.load_we && load_ok) begin
            time_mem[load_addr] <= entry_time;
            val_mem[load_addr]  <= entry_value;
        end
    end

    // Time is read one entry ahead of value: hi of segment j is time of entry j+1
    assign time_addr = j_reg + pci_pkg::IDX_W'(1);

    always_ff @(posedge clk) begin
        rd_time_reg <= time_mem[time_addr];
        rd_val_reg  <= val_mem[j_reg];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            points_reg <= pci_pkg::CFG_W'(1);
        end else if (cmd.cfg_we) begin
            points_reg <= cfg_data;
        end
    end

    // Clamp the point count into 1..MAX_POINTS
    assign points_ext = pci_pkg::CNT_W'(points_reg);
    always_comb begin
        if (points_ext == '0) begin
            active_n = pci_pkg::CNT_W'(1);
        end else if (points_ext > pci_pkg::CNT_W'(pci_pkg::MAX_POINTS)) begin
            active_n = pci_pkg::CNT_W'(pci_pkg::MAX_POINTS);
        end else begin
            active_n = points_ext;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.query_start) begin
            s_reg      <= start_time;
            e_reg      <= end_time;
            sq_sel_reg <= squared;
            n_last_reg <= pci_pkg::IDX_W'(active_n - pci_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            j_reg <= '0;
        end else if (cmd.query_start) begin
            j_reg <= '0;
        end else if (cmd.walk) begin
            j_reg <= j_reg + pci_pkg::IDX_W'(1);
        end
    end

    assign sts.walk_last  = (j_reg == n_last_reg);
    assign sts.pipe_empty = !(s1_valid_reg || s2_valid_reg || s3_valid_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.walk;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        s1_first_reg <= (j_reg == '0);
        s1_last_reg  <= sts.walk_last;
    end

    // Segment bounds, clipped to the query interval
    assign seg_lo = s1_first_reg ? '0 : {1'b0, prev_hi_reg};
    assign seg_hi = s1_last_reg ? pci_pkg::TIME_LIMIT : {1'b0, rd_time_reg};
    assign clip_a = (seg_lo > {1'b0, s_reg}) ? seg_lo : {1'b0, s_reg};
    assign clip_b = (seg_hi < {1'b0, e_reg}) ? seg_hi : {1'b0, e_reg};
    assign span   = (clip_b > clip_a) ? (clip_b - clip_a) : '0;
    assign vsq_full = (2*pci_pkg::VAL_W)'(rd_val_reg) * (2*pci_pkg::VAL_W)'(rd_val_reg);

    always_ff @(posedge clk) begin
        if (s1_valid_reg) begin
            prev_hi_reg <= rd_time_reg;
        end
        dt_reg   <= span;
        val2_reg <= rd_val_reg;
        vsq_reg  <= vsq_full[pci_pkg::VSQ_W-1:0];
    end

    always_ff @(posedge clk) begin
        pprod_reg <= pci_pkg::PPROD_W'(val2_reg) * pci_pkg::PPROD_W'($signed({1'b0, dt_reg}));
        sprod_reg <= pci_pkg::SPROD_W'(vsq_reg) * pci_pkg::SPROD_W'(dt_reg);
    end

    always_ff @(posedge clk) begin
        if (cmd.query_start) begin
            acc_plain_reg <= '0;
            acc_sq_reg    <= '0;
        end else if (s3_valid_reg) begin
            acc_plain_reg <= acc_plain_reg + pci_pkg::PACC_W'(pprod_reg);
            acc_sq_reg    <= acc_sq_reg + pci_pkg::SACC_W'(sprod_reg);
        end
    end

    // Round the square sum half up, then clamp either sum to the output range
    assign sq_sum    = {1'b0, acc_sq_reg} + pci_pkg::SQ_HALF;
    assign sq_ovf    = |sq_sum[pci_pkg::SACC_W:pci_pkg::SQ_SHIFT+pci_pkg::OUT_W-1];
    assign plain_top = acc_plain_reg[pci_pkg::PACC_W-1:pci_pkg::OUT_W-1];
    assign plain_ovf = !((&plain_top) || !(|plain_top));

    always_comb begin
        if (sq_sel_reg) begin
            sat_next = sq_ovf;
            if (sq_ovf) begin
                result_next = pci_pkg::OUT_MAX;
            end else begin
                result_next = {1'b0,
                    sq_sum[pci_pkg::SQ_SHIFT+pci_pkg::OUT_W-2:pci_pkg::SQ_SHIFT]};
            end
        end else begin
            sat_next = plain_ovf;
            if (!plain_ovf) begin
                result_next = acc_plain_reg[pci_pkg::OUT_W-1:0];
            end else if (acc_plain_reg[pci_pkg::PACC_W-1]) begin
                result_next = pci_pkg::OUT_MIN;
            end else begin
                result_next = pci_pkg::OUT_MAX;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.round) begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign integral  = $signed(result_reg);
    assign saturated = sat_reg;

endmodule

`default_nettype wire

// ===== sv/piecewise_constant_integral.sv =====
// Step-function integrator top level: command port, table load and integral queries.
// A load is stored at its accepting edge; a query walks the table, drains the
// pipeline, rounds and clamps the sum, then strobes done with the result.
// The block takes no new command until a query is through; the walk reads one
// table entry per cycle through the single read port of each table memory.
// Reset: rst_n clears the controller to idle and the point count to 1; the table
// itself is not cleared. The receiver cannot stall; done lasts exactly one cycle.
`default_nettype none

module piecewise_constant_integral (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Command channel: transfer when start is high and busy is low
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              op,
    input  wire logic [5:0]                        entry_index,
    input  wire logic [pci_pkg::TIME_W-1:0]        entry_time,
    input  wire logic signed [pci_pkg::VAL_W-1:0]  entry_value,
    input  wire logic [pci_pkg::TIME_W-1:0]        start_time,
    input  wire logic [pci_pkg::TIME_W-1:0]        end_time,
    input  wire logic                              squared,
    // Result: valid for the one cycle that done is high
    output logic                                   done,
    output logic signed [pci_pkg::OUT_W-1:0]       integral,
    output logic                                   saturated,
    // Configuration channel: points_in_use
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pci_pkg::CFG_W-1:0]         cfg_data
);

    pci_pkg::cmd_t cmd;
    pci_pkg::sts_t sts;

    // Sequence each transfer: load in place, or walk the table for a query
    pci_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .cfg_valid (cfg_valid),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .done      (done)
    );

    // Hold the table, clip each segment, multiply and accumulate, then round and clamp
    pci_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_data    (cfg_data),
        .entry_index (entry_index),
        .entry_time  (entry_time),
        .entry_value (entry_value),
        .start_time  (start_time),
        .end_time    (end_time),
        .squared     (squared),
        .integral    (integral),
        .saturated   (saturated)
    );

endmodule

`default_nettype wire

// ===== sv/pci_checker.sv =====
// Port-level checker for the step-function integrator, bound to the top level.
`default_nettype none

module pci_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic op,
    input wire logic busy,
    input wire logic done,
    input wire logic cfg_ready
);

    // The result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held longer than one cycle");

    // A result only shows while a query is in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");

    // A load completes at its transfer and leaves the block free
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !op) |=> (!busy && !done))
        else $error("load kept the block busy");

    // A query occupies the block and its result is not immediate
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op) |=> (busy && !done))
        else $error("query did not start its walk");

    // Configuration is only taken while idle
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready |-> !busy)
        else $error("configuration ready while busy");

endmodule

bind piecewise_constant_integral pci_checker u_pci_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (op),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== bench/piecewise_constant_integral_tb.sv =====
// Self-checking bench for the step-function integrator: table loads, integral queries, point counts.
`default_nettype none

module piecewise_constant_integral_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_W = pci_pkg::TIME_W;
    localparam int VAL_W  = pci_pkg::VAL_W;
    localparam int OUT_W  = pci_pkg::OUT_W;
    localparam int CFG_W  = pci_pkg::CFG_W;
    localparam int NPTS   = pci_pkg::MAX_POINTS;

    // Run shape: one directed phase at the reset point count, then one random
    // phase per point-count setting.
    localparam int NUM_SETTINGS  = 11;
    localparam int PHASE_ITEMS   = 132;
    localparam int PLAN_ITEMS    = 1470;
    // Margin before a register write, sized above the longest query at 64 points.
    localparam int SETTLE_CYCLES = 80;
    // Cycles with no transfer of any kind before the run is declared hung.
    localparam int STALL_LIMIT   = 3000;

    localparam longint OUT_HI     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint OUT_LO     = -OUT_HI - 64'sd1;
    localparam longint TIME_END   = 64'sd16777216;
    localparam longint SQ_ROUNDER = 64'sd1 <<< (pci_pkg::SQ_SHIFT - 1);

    typedef struct packed {
        logic                    op;
        logic [5:0]              slot;
        logic [TIME_W-1:0]       bp_time;
        logic signed [VAL_W-1:0] bp_value;
        logic [TIME_W-1:0]       t_from;
        logic [TIME_W-1:0]       t_to;
        logic                    sq_mode;
    } step_cmd_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] integral;
        logic                    saturated;
    } integral_t;

    typedef enum int {
        TBL_SORTED,     // increasing times spread over the whole range
        TBL_DENSE,      // increasing times packed into a narrow window
        TBL_SCRAMBLED,  // times in no order: empty and overlapping segments
        TBL_FOLDED      // times swing between the extremes, most negative values
    } table_style_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    start       = 1'b0;
    logic                    busy;
    logic                    op          = pci_pkg::OP_LOAD;
    logic [5:0]              entry_index = '0;
    logic [TIME_W-1:0]       entry_time  = '0;
    logic signed [VAL_W-1:0] entry_value = '0;
    logic [TIME_W-1:0]       start_time  = '0;
    logic [TIME_W-1:0]       end_time    = '0;
    logic                    squared     = 1'b0;
    logic                    done;
    logic signed [OUT_W-1:0] integral;
    logic                    saturated;
    logic                    cfg_valid   = 1'b0;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data    = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    piecewise_constant_integral u_top (.*);

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the table and the point count,
    // updated only on transfers that the block actually accepted.
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]       table_time  [NPTS];
    logic signed [VAL_W-1:0] table_value [NPTS];
    logic [CFG_W-1:0]        points_reg = 7'd1;

    step_cmd_t pending_cmds [$];        // items waiting for the driver
    integral_t expected_integrals [$];  // integrals owed by the block, oldest first

    // Generator's view of the breakpoint times, used to aim queries at edges
    logic [TIME_W-1:0] plan_time [NPTS];

    int cmds_accepted   = 0;
    int loads_done      = 0;
    int queries_done    = 0;
    int squared_done    = 0;
    int empty_done      = 0;
    int results_checked = 0;
    int settings_done   = 0;
    int error_count     = 0;
    int stall_cycles    = 0;

    // Register semantics: zero acts as one, anything past the table depth as the depth
    function automatic int clamp_points(input logic [CFG_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (int'(raw) > NPTS)
            return NPTS;
        return int'(raw);
    endfunction

    // Integral of the step function (or its square) over [t_from, t_to)
    function automatic integral_t integrate_steps(input step_cmd_t c);
        integral_t       r;
        int              n;
        int              i;
        longint          ts, te, seg_lo, seg_hi, a, b, dt, v, plain_sum;
        longint unsigned sq_sum, rounded;
        r         = '0;
        plain_sum = 0;
        sq_sum    = 0;
        n         = clamp_points(points_reg);
        ts        = c.t_from;
        te        = c.t_to;
        if (te > ts)
        begin
            for (i = 0; i < n; i++)
            begin
                // First entry reaches back to time zero, last one out to the end
                seg_lo = (i == 0) ? 64'sd0 : longint'(table_time[i]);
                seg_hi = (i + 1 < n) ? longint'(table_time[i + 1]) : TIME_END;
                a = (seg_lo > ts) ? seg_lo : ts;
                b = (seg_hi < te) ? seg_hi : te;
                if (b > a)
                begin
                    dt         = b - a;
                    v          = table_value[i];
                    plain_sum += v * dt;
                    sq_sum    += longint'(v * v) * dt;
                end
            end
        end
        if (c.sq_mode)
        begin
            // Square sum carries 30 fraction bits; round half up down to 16
            rounded = (sq_sum + SQ_ROUNDER) >> pci_pkg::SQ_SHIFT;
            if (rounded > OUT_HI)
            begin
                r.integral  = pci_pkg::OUT_MAX;
                r.saturated = 1'b1;
            end
            else
                r.integral = OUT_W'(rounded);
        end
        else if (plain_sum > OUT_HI)
        begin
            r.integral  = pci_pkg::OUT_MAX;
            r.saturated = 1'b1;
        end
        else if (plain_sum < OUT_LO)
        begin
            r.integral  = pci_pkg::OUT_MIN;
            r.saturated = 1'b1;
        end
        else
            r.integral = OUT_W'(plain_sum);
        return r;
    endfunction

    // Fold one accepted item into the table or the list of owed integrals
    function automatic void apply_cmd(input step_cmd_t c);
        if (c.op == pci_pkg::OP_LOAD)
        begin
            table_time[c.slot]  = c.bp_time;
            table_value[c.slot] = c.bp_value;
            loads_done++;
        end
        else
        begin
            expected_integrals.push_back(integrate_steps(c));
            queries_done++;
            if (c.sq_mode)
                squared_done++;
            if (c.t_to <= c.t_from)
                empty_done++;
        end
        cmds_accepted++;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Sender idling: light, then heavy, then none at all
    function automatic int sender_idle_pct();
        if (cmds_accepted < PLAN_ITEMS / 3)
            return 13;
        if (cmds_accepted < 2 * PLAN_ITEMS / 3)
            return 65;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next item, hold it until start meets !busy.
    // ------------------------------------------------------------------
    step_cmd_t on_port;

    always @(posedge clk or negedge rst_n)
    begin : drive_cmds
        step_cmd_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            // A transfer happens at this edge: the predictor sees it now
            if (start && !busy)
                apply_cmd(on_port);
            // Port is free when nothing is held or the held item just went in
            if (!start || !busy)
            begin
                if (pending_cmds.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct())
                begin
                    nxt         = pending_cmds.pop_front();
                    on_port     = nxt;
                    start       <= 1'b1;
                    op          <= nxt.op;
                    entry_index <= nxt.slot;
                    entry_time  <= nxt.bp_time;
                    entry_value <= nxt.bp_value;
                    start_time  <= nxt.t_from;
                    end_time    <= nxt.t_to;
                    squared     <= nxt.sq_mode;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: done is a one-cycle strobe, so check it at every edge.
    // Also run the watchdog on any kind of transfer.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        integral_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_integrals.size() == 0)
                    report_mismatch($sformatf("result with none owed: integral=%0d sat=%0b",
                                              integral, saturated));
                else
                begin
                    want = expected_integrals.pop_front();
                    results_checked++;
                    if (integral !== want.integral)
                        report_mismatch($sformatf("integral got %0d want %0d",
                                                  integral, want.integral));
                    if (saturated !== want.saturated)
                        report_mismatch($sformatf("saturated got %0b want %0b",
                                                  saturated, want.saturated));
                end
            end
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("watchdog: %0d cycles without a transfer", STALL_LIMIT);
                    $display("FAIL piecewise_constant_integral");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    // Value with extra weight on the extremes and zero
    function automatic logic signed [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return {1'b1, {(VAL_W - 1){1'b0}}};
        if (roll < 16)
            return {1'b0, {(VAL_W - 1){1'b1}}};
        if (roll < 22)
            return '0;
        return VAL_W'($urandom);
    endfunction

    function automatic void queue_load(input int slot, input logic [TIME_W-1:0] t,
                                       input logic signed [VAL_W-1:0] v);
        step_cmd_t c;
        c.op       = pci_pkg::OP_LOAD;
        c.slot     = 6'(slot);
        c.bp_time  = t;
        c.bp_value = v;
        // Query fields are don't-care on a load: toggle them anyway
        c.t_from   = TIME_W'($urandom);
        c.t_to     = TIME_W'($urandom);
        c.sq_mode  = 1'($urandom);
        pending_cmds.push_back(c);
        plan_time[slot] = t;
    endfunction

    function automatic void queue_query(input logic [TIME_W-1:0] t_from,
                                        input logic [TIME_W-1:0] t_to, input logic sq_mode);
        step_cmd_t c;
        c.op       = pci_pkg::OP_QUERY;
        c.slot     = 6'($urandom);
        c.bp_time  = TIME_W'($urandom);
        c.bp_value = VAL_W'($urandom);
        c.t_from   = t_from;
        c.t_to     = t_to;
        c.sq_mode  = sq_mode;
        pending_cmds.push_back(c);
    endfunction

    // Load entries 0..n-1 so that no query ever reads an unwritten slot
    function automatic void build_table(input int n, input table_style_t style);
        logic [TIME_W-1:0] times [$];
        logic [TIME_W-1:0] base;
        int                i;
        base = TIME_W'($urandom_range(0, 24'hFF_0000));
        for (i = 0; i < n; i++)
        begin
            case (style)
                TBL_DENSE:  times.push_back(base + TIME_W'($urandom_range(0, 16'hFFFF)));
                TBL_FOLDED: times.push_back((i % 2 == 1) ? '1 : '0);
                default:    times.push_back(TIME_W'($urandom));
            endcase
        end
        if (style == TBL_SORTED || style == TBL_DENSE)
            times.sort();
        for (i = 0; i < n; i++)
        begin
            if (style == TBL_FOLDED)
                queue_load(i, times[i], {1'b1, {(VAL_W - 1){1'b0}}});
            else
                queue_load(i, times[i], pick_value());
        end
    endfunction

    // Rewrite one entry; mostly keep the times in order, sometimes drop noise anywhere
    function automatic void queue_refresh(input int n);
        int                slot;
        logic [TIME_W-1:0] lo, hi, t;
        if ($urandom_range(0, 99) < 25)
        begin
            slot = $urandom_range(0, NPTS - 1);
            t    = TIME_W'($urandom);
        end
        else
        begin
            slot = $urandom_range(0, n - 1);
            lo   = (slot == 0) ? '0 : plan_time[slot - 1];
            hi   = (slot == n - 1) ? '1 : plan_time[slot + 1];
            t    = (lo <= hi) ? TIME_W'($urandom_range(hi, lo)) : TIME_W'($urandom);
        end
        queue_load(slot, t, pick_value());
    endfunction

    function automatic void queue_random_query(input int n);
        logic [TIME_W-1:0] a, b, tmp;
        int                pick;
        pick = $urandom_range(0, 99);
        a    = TIME_W'($urandom);
        b    = TIME_W'($urandom);
        if (pick < 10)
        begin
            // Empty interval: end at or below start
            if (b > a)
            begin
                tmp = a;
                a   = b;
                b   = tmp;
            end
            if (pick < 4)
                b = a;
        end
        else
        begin
            if (pick < 20)
            begin
                if (pick < 15)
                    a = '0;
                b = '1;
            end
            else if (pick < 60)
            begin
                // Land near breakpoints so the clipping at both ends is exercised
                a = TIME_W'(plan_time[$urandom_range(0, n - 1)] + $urandom_range(0, 64) - 32);
                b = TIME_W'(plan_time[$urandom_range(0, n - 1)] + $urandom_range(0, 64) - 32);
            end
            if (a > b)
            begin
                tmp = a;
                a   = b;
                b   = tmp;
            end
        end
        queue_query(a, b, 1'($urandom));
    endfunction

    function automatic logic [CFG_W-1:0] setting_for(input int phase);
        case (phase)
            0:       return 7'd64;
            1:       return 7'd0;
            2:       return 7'd127;
            3:       return 7'd65;
            4:       return 7'd2;
            5:       return 7'd37;
            6:       return 7'd1;
            7:       return 7'd12;
            8:       return 7'd64;
            9:       return 7'd5;
            default: return 7'd24;
        endcase
    endfunction

    function automatic table_style_t pick_style();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return TBL_SORTED;
        if (roll < 70)
            return TBL_DENSE;
        if (roll < 88)
            return TBL_SCRAMBLED;
        return TBL_FOLDED;
    endfunction

    // Block is idle only once the driver is empty and every integral has come back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || start || expected_integrals.size() != 0);
        // Let a trailing load finish before touching the register
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_points(input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        points_reg = val;
        settings_done++;
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed checks at one point, then one random phase
    // per register setting with the block drained in between.
    // ------------------------------------------------------------------
    initial
    begin
        int           phase;
        int           k;
        int           n;
        table_style_t style;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one entry in use after reset, so entry 0 covers all time
        queue_load(0, '0, {1'b1, {(VAL_W - 1){1'b0}}});
        queue_query('0, '1, 1'b0);
        queue_query('0, '1, 1'b1);
        queue_query(24'd7, 24'd7, 1'b0);          // empty: end equals start
        queue_query('1, '0, 1'b1);                // empty: end below start
        queue_load(0, '1, {1'b0, {(VAL_W - 1){1'b1}}});
        queue_query('0, '1, 1'b0);
        queue_query('0, '1, 1'b1);
        queue_query('0, 24'd1, 1'b0);             // one-tick span
        queue_query(24'hFF_FFFE, '1, 1'b1);
        queue_load(NPTS - 1, '1, -16'sd1);        // highest slot, not in use yet
        queue_load(0, 24'h5A_5A5A, '0);
        queue_query(24'h12_3456, 24'hAB_CDEF, 1'b1);
        queue_load(0, 24'hA5_A5A5, -16'sd1);
        queue_query(24'h12_3456, 24'hAB_CDEF, 1'b0);
        queue_query(24'h12_3456, 24'hAB_CDEF, 1'b1);
        wait_drained();

        for (phase = 0; phase < NUM_SETTINGS; phase++)
        begin
            write_points(setting_for(phase));
            n     = clamp_points(setting_for(phase));
            // First full table: overlapping segments at the largest magnitude
            style = (phase == 0) ? TBL_FOLDED : pick_style();
            build_table(n, style);
            for (k = n; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) < 60)
                    queue_random_query(n);
                else
                    queue_refresh(n);
            end
            wait_drained();
        end

        $display("covered %0d loads and %0d queries (%0d squared, %0d empty) over %0d settings",
                 loads_done, queries_done, squared_done, empty_done, settings_done);
        $display("checked %0d integrals, %0d mismatches", results_checked, error_count);
        if (error_count == 0 && expected_integrals.size() == 0)
            $display("PASS piecewise_constant_integral");
        else
            $display("FAIL piecewise_constant_integral");
        $finish;
    end

endmodule

`default_nettype wire
